// ----- rtl/svgpn_pkg.sv -----
`default_nettype none

package svgpn_pkg;

	// Default coordinate width; every sum saturates to this many signed bits
	localparam int unsigned COORD_WIDTH_DEF = 32;

	// round(2^32 * pi / 180)
	localparam logic signed [27:0] DEG_RAD_Q32 = 28'sd74961321;

	// Path command opcodes
	typedef enum logic [3:0] {
		OP_MOVE    = 4'd0,
		OP_LINE    = 4'd1,
		OP_HLINE   = 4'd2,
		OP_VLINE   = 4'd3,
		OP_CUBIC   = 4'd4,
		OP_SCUBIC  = 4'd5,
		OP_QUAD    = 4'd6,
		OP_SQUAD   = 4'd7,
		OP_ARC     = 4'd8,
		OP_CLOSE   = 4'd9
	} op_t;

	// Absolute path element kinds
	typedef enum logic [2:0] {
		ELEM_MOVE  = 3'd0,
		ELEM_LINE  = 3'd1,
		ELEM_CURVE = 3'd2,
		ELEM_ARC   = 3'd3,
		ELEM_CLOSE = 3'd4
	} elem_t;

	// Kind of the previous command, for smooth curve reflection
	typedef enum logic [1:0] {
		KIND_NONE  = 2'd0,
		KIND_CUBIC = 2'd1,
		KIND_QUAD  = 2'd2
	} kind_t;

	// One decoded path command request
	typedef struct packed {
		logic [3:0]         op;
		logic               absolute;
		logic               new_path;
		logic signed [31:0] arg_a;
		logic signed [31:0] arg_b;
		logic signed [31:0] arg_c;
		logic signed [31:0] arg_d;
		logic signed [31:0] arg_e;
		logic signed [31:0] arg_f;
		logic               large_arc_in;
		logic               sweep_in;
	} cmd_t;

	// One absolute path element
	typedef struct packed {
		logic [2:0]         element_type;
		logic signed [31:0] ctrl1_x;
		logic signed [31:0] ctrl1_y;
		logic signed [31:0] ctrl2_x;
		logic signed [31:0] ctrl2_y;
		logic signed [31:0] end_x;
		logic signed [31:0] end_y;
		logic signed [31:0] radius_x;
		logic signed [31:0] radius_y;
		logic signed [31:0] rotation_rad;
		logic               large_arc_out;
		logic               sweep_out;
	} elem_pkt_t;

endpackage

`default_nettype wire

// ----- rtl/svg_path_command_normalizer.sv -----
`default_nettype none

// SVG path command normalizer.
// Input channel cmd/cmd_valid/cmd_stall carries one decoded path command per
// request; output channel elem/elem_valid/elem_stall carries one absolute path
// element (moveto, lineto, cubic curveto, arcto or closepath) per command.
// A command is taken into an input register, resolved against the current
// point and the stored control points by combinational logic, and written
// to the result register together with the updated state. A command thus
// passes through the input and then the result register, and elem_stall can
// hold it in either. Throughput: one command per clock while elem_stall is
// low; the state loop (current point, control points, previous kind) closes
// through the combinational input-to-result logic.
// When elem_stall is high a full result register holds, the input register
// still takes one more command, and cmd_stall rises only when both are full.
// Reset (arst_n low) empties both registers and clears the current point,
// both control points and the previous command kind to zero.
// Coordinates are signed COORD_WIDTH-bit values and every sum saturates to
// that range; the element fields carry the low 32 bits.
module svg_path_command_normalizer import svgpn_pkg::*; #(
	parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_stall,
	input  cmd_t      cmd,
	output logic      elem_valid,
	input  logic      elem_stall,
	output elem_pkt_t elem
);

	localparam int unsigned CW = COORD_WIDTH;
	localparam int unsigned XW = ((CW > 32) ? CW : 32) + 2;

	localparam logic signed [XW-1:0] CMAX = {{(XW - CW + 1){1'b0}}, {(CW - 1){1'b1}}};
	localparam logic signed [XW-1:0] CMIN = ~CMAX;

	typedef logic signed [CW-1:0] coord_t;

	// Saturate a wide signed value to the coordinate range
	function automatic coord_t sat(input logic signed [XW-1:0] v);
		if (v > CMAX) return CMAX[CW-1:0];
		if (v < CMIN) return CMIN[CW-1:0];
		return v[CW-1:0];
	endfunction

	function automatic logic signed [XW-1:0] ext(input coord_t v);
		return {{(XW - CW){v[CW-1]}}, v};
	endfunction

	function automatic coord_t from_port(input logic signed [31:0] v);
		return sat({{(XW - 32){v[31]}}, v});
	endfunction

	// Absolute operand, or relative operand added to the base coordinate
	function automatic coord_t place(input logic absl, input coord_t base, input coord_t a);
		if (absl) return a;
		return sat(ext(base) + ext(a));
	endfunction

	// Reflection of a control point through the current point
	function automatic coord_t reflect(input coord_t cur, input coord_t ctl);
		return sat((ext(cur) <<< 1) - ext(ctl));
	endfunction

	// Pipeline registers and state
	cmd_t      cmd_s1;
	logic      cmd_valid_s1;
	elem_pkt_t res_s2;
	logic      res_valid_s2;

	coord_t cur_x_q, cur_y_q;
	coord_t cub_x_q, cub_y_q;
	coord_t quad_x_q, quad_y_q;
	kind_t  kind_q;

	logic advance;
	logic fire;

	// Effective state after the optional new-path clear
	coord_t cx, cy, cbx, cby, qdx, qdy;
	kind_t  pk;

	// Operands and placed coordinates
	coord_t ax, ay, az, aw, ae, af;
	coord_t pa_x, pa_y, pc_x, pd_y, pe_x, pf_y;
	coord_t rc_x, rc_y, rq_x, rq_y;

	// Quadratic resolution
	coord_t qx, qy, qex, qey;
	coord_t w1x, w1y, w2x, w2y;

	// Arc rotation
	logic signed [59:0] deg_w, prod_w, rnd_w;
	coord_t             rot;

	// Next state and result
	coord_t    nx, ny, ncbx, ncby, nqdx, nqdy;
	kind_t     nkind;
	elem_pkt_t res_d;

	// Handshake
	assign advance    = !res_valid_s2 || !elem_stall;
	assign fire       = cmd_valid_s1 && advance;
	assign cmd_stall  = cmd_valid_s1 && !advance;
	assign elem_valid = res_valid_s2;
	assign elem       = res_s2;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_s1 <= 1'b0;
		end else if (!cmd_stall) begin
			cmd_valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!cmd_stall) begin
			cmd_s1 <= cmd;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (advance) begin
			res_valid_s2 <= cmd_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res_d;
		end
	end

	// Path state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q  <= '0;
			cur_y_q  <= '0;
			cub_x_q  <= '0;
			cub_y_q  <= '0;
			quad_x_q <= '0;
			quad_y_q <= '0;
			kind_q   <= KIND_NONE;
		end else if (fire) begin
			cur_x_q  <= nx;
			cur_y_q  <= ny;
			cub_x_q  <= ncbx;
			cub_y_q  <= ncby;
			quad_x_q <= nqdx;
			quad_y_q <= nqdy;
			kind_q   <= nkind;
		end
	end

	// Operand preparation and placement
	always_comb begin
		if (cmd_s1.new_path) begin
			cx  = '0;
			cy  = '0;
			cbx = '0;
			cby = '0;
			qdx = '0;
			qdy = '0;
			pk  = KIND_NONE;
		end else begin
			cx  = cur_x_q;
			cy  = cur_y_q;
			cbx = cub_x_q;
			cby = cub_y_q;
			qdx = quad_x_q;
			qdy = quad_y_q;
			pk  = kind_q;
		end

		ax = from_port(cmd_s1.arg_a);
		ay = from_port(cmd_s1.arg_b);
		az = from_port(cmd_s1.arg_c);
		aw = from_port(cmd_s1.arg_d);
		ae = from_port(cmd_s1.arg_e);
		af = from_port(cmd_s1.arg_f);

		pa_x = place(cmd_s1.absolute, cx, ax);
		pa_y = place(cmd_s1.absolute, cy, ay);
		pc_x = place(cmd_s1.absolute, cx, az);
		pd_y = place(cmd_s1.absolute, cy, aw);
		pe_x = place(cmd_s1.absolute, cx, ae);
		pf_y = place(cmd_s1.absolute, cy, af);

		rc_x = (pk == KIND_CUBIC) ? reflect(cx, cbx) : cx;
		rc_y = (pk == KIND_CUBIC) ? reflect(cy, cby) : cy;
		rq_x = (pk == KIND_QUAD) ? reflect(cx, qdx) : cx;
		rq_y = (pk == KIND_QUAD) ? reflect(cy, qdy) : cy;

		// quadratic control and end point, explicit or smooth
		if (cmd_s1.op == OP_SQUAD) begin
			qx  = rq_x;
			qy  = rq_y;
			qex = pa_x;
			qey = pa_y;
		end else begin
			qx  = pa_x;
			qy  = pa_y;
			qex = pc_x;
			qey = pd_y;
		end
	end

	// Degree-to-radian conversion, rounded half away from zero
	always_comb begin
		deg_w  = 60'(cmd_s1.arg_c);
		prod_w = deg_w * 60'(DEG_RAD_Q32);
		rnd_w  = prod_w + (prod_w[59] ? 60'sh7FFFFFFF : 60'sh80000000);
		rot    = sat({{(XW - 28){rnd_w[59]}}, rnd_w[59:32]});
	end

	svgpn_weigh #(.COORD_WIDTH(CW)) u_weigh_c1x (.base(cx),  .ctrl(qx), .weighed(w1x));
	svgpn_weigh #(.COORD_WIDTH(CW)) u_weigh_c1y (.base(cy),  .ctrl(qy), .weighed(w1y));
	svgpn_weigh #(.COORD_WIDTH(CW)) u_weigh_c2x (.base(qex), .ctrl(qx), .weighed(w2x));
	svgpn_weigh #(.COORD_WIDTH(CW)) u_weigh_c2y (.base(qey), .ctrl(qy), .weighed(w2y));

	// Element build and next state
	always_comb begin
		nx    = cx;
		ny    = cy;
		ncbx  = cbx;
		ncby  = cby;
		nqdx  = qdx;
		nqdy  = qdy;
		nkind = KIND_NONE;
		res_d = '0;

		unique case (cmd_s1.op)
			OP_MOVE: begin
				res_d.element_type = ELEM_MOVE;
				nx = pa_x;
				ny = pa_y;
			end
			OP_LINE: begin
				res_d.element_type = ELEM_LINE;
				nx = pa_x;
				ny = pa_y;
			end
			OP_HLINE: begin
				res_d.element_type = ELEM_LINE;
				nx = pa_x;
			end
			OP_VLINE: begin
				res_d.element_type = ELEM_LINE;
				ny = pa_y;
			end
			OP_CUBIC: begin
				res_d.element_type = ELEM_CURVE;
				res_d.ctrl1_x = 32'(pa_x);
				res_d.ctrl1_y = 32'(pa_y);
				res_d.ctrl2_x = 32'(pc_x);
				res_d.ctrl2_y = 32'(pd_y);
				ncbx  = pc_x;
				ncby  = pd_y;
				nx    = pe_x;
				ny    = pf_y;
				nkind = KIND_CUBIC;
			end
			OP_SCUBIC: begin
				res_d.element_type = ELEM_CURVE;
				res_d.ctrl1_x = 32'(rc_x);
				res_d.ctrl1_y = 32'(rc_y);
				res_d.ctrl2_x = 32'(pa_x);
				res_d.ctrl2_y = 32'(pa_y);
				ncbx  = pa_x;
				ncby  = pa_y;
				nx    = pc_x;
				ny    = pd_y;
				nkind = KIND_CUBIC;
			end
			OP_QUAD, OP_SQUAD: begin
				res_d.element_type = ELEM_CURVE;
				res_d.ctrl1_x = 32'(w1x);
				res_d.ctrl1_y = 32'(w1y);
				res_d.ctrl2_x = 32'(w2x);
				res_d.ctrl2_y = 32'(w2y);
				nqdx  = qx;
				nqdy  = qy;
				nx    = qex;
				ny    = qey;
				nkind = KIND_QUAD;
			end
			OP_ARC: begin
				res_d.element_type  = ELEM_ARC;
				res_d.radius_x      = 32'(ax);
				res_d.radius_y      = 32'(ay);
				res_d.rotation_rad  = 32'(rot);
				res_d.large_arc_out = cmd_s1.large_arc_in;
				res_d.sweep_out     = cmd_s1.sweep_in;
				nx = pe_x;
				ny = pf_y;
			end
			// closepath and unused opcodes
			default: begin
				res_d.element_type = ELEM_CLOSE;
			end
		endcase

		res_d.end_x = 32'(nx);
		res_d.end_y = 32'(ny);
	end

endmodule

`default_nettype wire

// ----- rtl/svgpn_weigh.sv -----
`default_nettype none

// Quadratic-to-cubic control point: round((base + 2*ctrl) / 3).
// Floor division by 3 is done by a reciprocal multiply on an offset,
// non-negative operand; the offset is a multiple of 3 and is removed after.
module svgpn_weigh import svgpn_pkg::*; #(
	parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic signed [COORD_WIDTH-1:0] base,
	input  logic signed [COORD_WIDTH-1:0] ctrl,
	output logic signed [COORD_WIDTH-1:0] weighed
);

	localparam int unsigned SW = COORD_WIDTH + 2;
	localparam int unsigned NW = COORD_WIDTH + 3;
	localparam int unsigned MW = NW + 1;
	localparam int unsigned PW = NW + MW;

	localparam logic [NW-1:0] OFFSET = NW'(3) << COORD_WIDTH;
	localparam logic [MW-1:0] RECIP = MW'(({1'b1, {(NW + 2){1'b0}}} / 3) + 1);

	logic signed [SW-1:0] sum;
	logic [NW-1:0]        shifted;
	logic [PW-1:0]        prod;
	logic [NW-2:0]        quot;

	// base + 2*ctrl + 1, then floor divide by 3
	always_comb begin
		sum     = {{2{base[COORD_WIDTH-1]}}, base} + {ctrl[COORD_WIDTH-1], ctrl, 1'b0} + SW'(1);
		shifted = {sum[SW-1], sum} + OFFSET;
		prod    = PW'(shifted) * PW'(RECIP);
		quot    = prod[NW+2 +: NW-1];
		// quotient carries +2^COORD_WIDTH from the offset; low bits are the answer
		weighed = quot[COORD_WIDTH-1:0];
	end

endmodule

`default_nettype wire

// ----- rtl/svgpn_checker.sv -----
`default_nettype none

// Port-level checks for the path command normalizer
module svgpn_checker import svgpn_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      cmd_valid,
	input logic      cmd_stall,
	input logic      elem_valid,
	input logic      elem_stall,
	input elem_pkt_t elem
);

	// A stalled element holds
	a_elem_hold: assert property (@(posedge clk) disable iff (!arst_n)
		elem_valid && elem_stall |=> elem_valid && $stable(elem))
		else $error("stalled element changed");

	// Input backs up only when the output register is full and stalled
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> elem_valid && elem_stall)
		else $error("command stalled without output backpressure");

	// A new element follows a request that was accepted and passed through the input register
	a_elem_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(elem_valid) |-> $past(cmd_valid && !cmd_stall, 2))
		else $error("element without accepted request");

	// Control points are zero unless the element is a curve
	a_ctrl_zero: assert property (@(posedge clk) disable iff (!arst_n)
		elem_valid && (elem.element_type != ELEM_CURVE) |->
			elem.ctrl1_x == 32'sd0 && elem.ctrl1_y == 32'sd0 &&
			elem.ctrl2_x == 32'sd0 && elem.ctrl2_y == 32'sd0)
		else $error("control point set on non-curve element");

	// Arc fields are zero unless the element is an arc
	a_arc_zero: assert property (@(posedge clk) disable iff (!arst_n)
		elem_valid && (elem.element_type != ELEM_ARC) |->
			elem.radius_x == 32'sd0 && elem.radius_y == 32'sd0 &&
			elem.rotation_rad == 32'sd0 && !elem.large_arc_out && !elem.sweep_out)
		else $error("arc field set on non-arc element");

endmodule

bind svg_path_command_normalizer svgpn_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.cmd_valid  (cmd_valid),
	.cmd_stall  (cmd_stall),
	.elem_valid (elem_valid),
	.elem_stall (elem_stall),
	.elem       (elem)
);

`default_nettype wire

// ----- verif/svg_path_command_normalizer_tb.sv -----
`default_nettype none

module svg_path_command_normalizer_tb;
	import svgpn_pkg::*;

	localparam int WATCHDOG_LIMIT   = 1000;
	localparam int LONG_HOLD_CYCLES = 60;
	localparam int RANDOM_ITEMS     = 400;
	localparam int QUIET_TAIL       = 60;
	localparam int DRAIN_CYCLES     = 4;

	localparam logic signed [31:0] MAXC = 32'sh7fff_ffff;
	localparam logic signed [31:0] MINC = 32'sh8000_0000;
	localparam logic signed [31:0] ONE  = 32'sh0001_0000;

	// Predicts one absolute path element per command and checks the block's output
	class element_scoreboard;
		localparam longint COORD_HI = 64'sd2147483647;
		localparam longint COORD_LO = -64'sd2147483648;
		// round(2^32 * pi / 180)
		localparam longint DEG_TO_RAD_SCALE = 64'sd74961321;

		longint    cur_x, cur_y;
		longint    cubic_x, cubic_y;
		longint    quad_x, quad_y;
		kind_t     prev_kind;
		elem_pkt_t expected_elems[$];
		int        mismatches;
		int        checked;

		function new();
			clear_state();
			mismatches = 0;
			checked = 0;
		endfunction

		function void clear_state();
			cur_x = 0;
			cur_y = 0;
			cubic_x = 0;
			cubic_y = 0;
			quad_x = 0;
			quad_y = 0;
			prev_kind = KIND_NONE;
		endfunction

		function int pending();
			return expected_elems.size();
		endfunction

		function longint clamp_coord(longint v);
			if (v > COORD_HI)
				return COORD_HI;
			if (v < COORD_LO)
				return COORD_LO;
			return v;
		endfunction

		function longint place(bit is_abs, longint base, longint v);
			return is_abs ? v : clamp_coord(base + v);
		endfunction

		function longint reflect(longint cur, longint ctrl);
			return clamp_coord(2 * cur - ctrl);
		endfunction

		// (p + 2q) / 3 rounded to nearest, via floor((p + 2q + 1) / 3)
		function longint weigh_third(longint p, longint q);
			longint t;
			longint quo;
			t = p + 2 * q + 1;
			quo = t / 3;
			if (t % 3 < 0)
				quo = quo - 1;
			return clamp_coord(quo);
		endfunction

		// degrees Q16.16 to radians Q16.16, halves rounded away from zero
		function longint deg_to_rad(longint deg);
			longint prod;
			longint mag;
			prod = deg * DEG_TO_RAD_SCALE;
			mag = (prod < 0) ? -prod : prod;
			mag = (mag + 64'sd2147483648) >>> 32;
			return clamp_coord((prod < 0) ? -mag : mag);
		endfunction

		// Work out the element for an accepted command request
		function void note_command(cmd_t c);
			elem_pkt_t e;
			longint    arg[6];
			longint    c1x, c1y, c2x, c2y, qx, qy, ex, ey;
			kind_t     kind;
			if (c.new_path)
				clear_state();
			arg[0] = longint'($signed(c.arg_a));
			arg[1] = longint'($signed(c.arg_b));
			arg[2] = longint'($signed(c.arg_c));
			arg[3] = longint'($signed(c.arg_d));
			arg[4] = longint'($signed(c.arg_e));
			arg[5] = longint'($signed(c.arg_f));
			e = '0;
			kind = KIND_NONE;
			case (c.op)
				OP_MOVE, OP_LINE: begin
					e.element_type = (c.op == OP_MOVE) ? ELEM_MOVE : ELEM_LINE;
					cur_x = place(c.absolute, cur_x, arg[0]);
					cur_y = place(c.absolute, cur_y, arg[1]);
				end
				OP_HLINE: begin
					e.element_type = ELEM_LINE;
					cur_x = place(c.absolute, cur_x, arg[0]);
				end
				OP_VLINE: begin
					e.element_type = ELEM_LINE;
					cur_y = place(c.absolute, cur_y, arg[1]);
				end
				OP_CUBIC, OP_SCUBIC: begin
					if (c.op == OP_CUBIC) begin
						c1x = place(c.absolute, cur_x, arg[0]);
						c1y = place(c.absolute, cur_y, arg[1]);
						c2x = place(c.absolute, cur_x, arg[2]);
						c2y = place(c.absolute, cur_y, arg[3]);
						ex = place(c.absolute, cur_x, arg[4]);
						ey = place(c.absolute, cur_y, arg[5]);
					end else begin
						// smooth: mirror the last cubic control, else start at the pen
						if (prev_kind == KIND_CUBIC) begin
							c1x = reflect(cur_x, cubic_x);
							c1y = reflect(cur_y, cubic_y);
						end else begin
							c1x = cur_x;
							c1y = cur_y;
						end
						c2x = place(c.absolute, cur_x, arg[0]);
						c2y = place(c.absolute, cur_y, arg[1]);
						ex = place(c.absolute, cur_x, arg[2]);
						ey = place(c.absolute, cur_y, arg[3]);
					end
					e.element_type = ELEM_CURVE;
					e.ctrl1_x = 32'(c1x);
					e.ctrl1_y = 32'(c1y);
					e.ctrl2_x = 32'(c2x);
					e.ctrl2_y = 32'(c2y);
					cubic_x = c2x;
					cubic_y = c2y;
					cur_x = ex;
					cur_y = ey;
					kind = KIND_CUBIC;
				end
				OP_QUAD, OP_SQUAD: begin
					if (c.op == OP_QUAD) begin
						qx = place(c.absolute, cur_x, arg[0]);
						qy = place(c.absolute, cur_y, arg[1]);
						ex = place(c.absolute, cur_x, arg[2]);
						ey = place(c.absolute, cur_y, arg[3]);
					end else begin
						if (prev_kind == KIND_QUAD) begin
							qx = reflect(cur_x, quad_x);
							qy = reflect(cur_y, quad_y);
						end else begin
							qx = cur_x;
							qy = cur_y;
						end
						ex = place(c.absolute, cur_x, arg[0]);
						ey = place(c.absolute, cur_y, arg[1]);
					end
					// degree raise: each control two thirds of the way from its end point toward the quad control
					e.element_type = ELEM_CURVE;
					e.ctrl1_x = 32'(weigh_third(cur_x, qx));
					e.ctrl1_y = 32'(weigh_third(cur_y, qy));
					e.ctrl2_x = 32'(weigh_third(ex, qx));
					e.ctrl2_y = 32'(weigh_third(ey, qy));
					quad_x = qx;
					quad_y = qy;
					cur_x = ex;
					cur_y = ey;
					kind = KIND_QUAD;
				end
				OP_ARC: begin
					e.element_type = ELEM_ARC;
					e.radius_x = 32'(arg[0]);
					e.radius_y = 32'(arg[1]);
					e.rotation_rad = 32'(deg_to_rad(arg[2]));
					e.large_arc_out = c.large_arc_in;
					e.sweep_out = c.sweep_in;
					cur_x = place(c.absolute, cur_x, arg[4]);
					cur_y = place(c.absolute, cur_y, arg[5]);
				end
				default: begin
					// closepath and unused opcodes
					e.element_type = ELEM_CLOSE;
				end
			endcase
			e.end_x = 32'(cur_x);
			e.end_y = 32'(cur_y);
			prev_kind = kind;
			expected_elems = {expected_elems, e};
		endfunction

		task report_mismatch(string what);
			$display("MISMATCH element %0d: %s", checked, what);
			mismatches++;
		endtask

		task check_field(string name, logic [31:0] got, logic [31:0] want);
			if (got !== want)
				report_mismatch($sformatf("%s got %h want %h", name, got, want));
		endtask

		// Compare an accepted element with the oldest prediction
		task check_element(elem_pkt_t got);
			elem_pkt_t want;
			if (expected_elems.size() == 0) begin
				report_mismatch($sformatf("element type %0d with no command pending",
					got.element_type));
			end else begin
				want = expected_elems.pop_front();
				check_field("element_type", 32'(got.element_type),
					32'(want.element_type));
				check_field("ctrl1_x", got.ctrl1_x, want.ctrl1_x);
				check_field("ctrl1_y", got.ctrl1_y, want.ctrl1_y);
				check_field("ctrl2_x", got.ctrl2_x, want.ctrl2_x);
				check_field("ctrl2_y", got.ctrl2_y, want.ctrl2_y);
				check_field("end_x", got.end_x, want.end_x);
				check_field("end_y", got.end_y, want.end_y);
				check_field("radius_x", got.radius_x, want.radius_x);
				check_field("radius_y", got.radius_y, want.radius_y);
				check_field("rotation_rad", got.rotation_rad, want.rotation_rad);
				check_field("large_arc_out", 32'(got.large_arc_out),
					32'(want.large_arc_out));
				check_field("sweep_out", 32'(got.sweep_out), 32'(want.sweep_out));
			end
			checked++;
		endtask
	endclass

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      cmd_valid = 1'b0;
	logic      cmd_stall;
	cmd_t      cmd = '0;
	logic      elem_valid;
	logic      elem_stall = 1'b0;
	elem_pkt_t elem;

	element_scoreboard sb = new();

	bit long_hold = 1'b0;
	bit quiet = 1'b0;
	int idle_cycles = 0;

	svg_path_command_normalizer DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.cmd        (cmd),
		.elem_valid (elem_valid),
		.elem_stall (elem_stall),
		.elem       (elem)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Flag arguments take 0 or 1; bit 0 is used
	function automatic cmd_t build_command(logic [3:0] op, int is_abs, int np,
		logic signed [31:0] a, logic signed [31:0] b, logic signed [31:0] c,
		logic signed [31:0] d, logic signed [31:0] e, logic signed [31:0] f,
		int large_arc, int sweep);
		cmd_t r;
		r.op = op;
		r.absolute = is_abs[0];
		r.new_path = np[0];
		r.arg_a = a;
		r.arg_b = b;
		r.arg_c = c;
		r.arg_d = d;
		r.arg_e = e;
		r.arg_f = f;
		r.large_arc_in = large_arc[0];
		r.sweep_in = sweep[0];
		return r;
	endfunction

	// Mostly moderate coordinates, with extremes and full-range noise mixed in
	function automatic logic signed [31:0] rand_coord();
		logic signed [31:0] v;
		case ($urandom_range(0, 11))
			0: v = MAXC;
			1: v = MINC;
			2, 3: v = $urandom;
			default: begin
				v = $urandom_range(0, 32'h0800_0000);
				v = v - 32'sh0400_0000;
			end
		endcase
		return v;
	endfunction

	function automatic logic signed [31:0] rand_rotation();
		logic signed [31:0] v;
		if ($urandom_range(0, 4) == 0) begin
			v = $urandom;
		end else begin
			v = $urandom_range(0, 720 * 65536);
			v = v - 360 * 65536;
		end
		return v;
	endfunction

	function automatic cmd_t random_command(logic [3:0] op, bit np);
		return build_command(op, int'($urandom_range(0, 1)), int'(np), rand_coord(),
			rand_coord(), (op == OP_ARC) ? rand_rotation() : rand_coord(), rand_coord(),
			rand_coord(), rand_coord(), int'($urandom_range(0, 1)),
			int'($urandom_range(0, 1)));
	endfunction

	// Offer one command request, optionally after a short gap, until accepted
	task automatic issue(cmd_t c);
		if (!quiet && !long_hold && $urandom_range(0, 3) == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		cmd <= c;
		cmd_valid <= 1'b1;
		do
			@(posedge clk);
		while (cmd_stall);
		sb.note_command(c);
	endtask

	task automatic run_directed();
		// saturation of a relative line, then relative and absolute single-axis lines
		issue(build_command(OP_MOVE, 1, 1, MAXC, MINC, 0, 0, 0, 0, 0, 0));
		issue(build_command(OP_LINE, 0, 0, MAXC, MINC, 0, 0, 0, 0, 0, 0));
		issue(build_command(OP_HLINE, 0, 0, MINC, MAXC, 0, 0, 0, 0, 0, 0));
		issue(build_command(OP_VLINE, 0, 0, MAXC, MAXC, 0, 0, 0, 0, 0, 0));
		issue(build_command(OP_HLINE, 1, 0, 3 * ONE, MINC, 0, 0, 0, 0, 0, 0));
		issue(build_command(OP_VLINE, 1, 0, MAXC, -5 * ONE, 0, 0, 0, 0, 0, 0));
		// smooth cubic after a line starts at the current point
		issue(build_command(OP_SCUBIC, 1, 0, ONE, 2 * ONE, 4 * ONE, -ONE, 0, 0, 0, 0));
		issue(build_command(OP_CUBIC, 1, 0, MAXC, MINC, MINC, MAXC, ONE, -ONE, 0, 0));
		// reflection of a far control saturates
		issue(build_command(OP_SCUBIC, 0, 0, ONE, ONE, 2 * ONE, 2 * ONE, 0, 0, 0, 0));
		issue(build_command(OP_QUAD, 0, 0, 7 * ONE, -2 * ONE, MAXC, MINC, 0, 0, 0, 0));
		issue(build_command(OP_SQUAD, 1, 0, ONE, ONE, 0, 0, 0, 0, 0, 0));
		issue(build_command(OP_SQUAD, 0, 0, 5, -7, 0, 0, 0, 0, 0, 0));
		issue(build_command(OP_CUBIC, 0, 0, 1, 2, -3, 4, 5, -6, 0, 0));
		// smooth quad after a cubic: control is the current point
		issue(build_command(OP_SQUAD, 0, 0, 11, -13, 0, 0, 0, 0, 0, 0));
		issue(build_command(OP_ARC, 1, 0, MAXC, MINC, MAXC, MAXC, 9 * ONE, -ONE, 1, 0));
		issue(build_command(OP_ARC, 0, 0, MINC, MAXC, MINC, MINC, MAXC, MAXC, 0, 1));
		issue(build_command(OP_ARC, 1, 0, ONE, 2 * ONE, 90 * ONE, 0, 0, 0, 1, 1));
		issue(build_command(OP_ARC, 0, 0, 0, -1, -45 * ONE + 1, 0, -ONE, ONE, 0, 0));
		issue(build_command(OP_CLOSE, 1, 0, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, 1, 1));
		issue(build_command(4'd10, 0, 0, MINC, MINC, MINC, MINC, MINC, MINC, 1, 1));
		issue(build_command(4'd15, 1, 0, ONE, ONE, ONE, ONE, ONE, ONE, 0, 0));
		issue(build_command(OP_CUBIC, 1, 0, ONE, ONE, 2 * ONE, 3 * ONE, 4 * ONE, 5, 0, 0));
		// new path clears the previous kind before the smooth cubic is resolved
		issue(build_command(OP_SCUBIC, 1, 1, ONE, -ONE, 3 * ONE, 3 * ONE, 0, 0, 0, 0));
		issue(build_command(OP_MOVE, 0, 0, -ONE, MINC, 0, 0, 0, 0, 0, 0));
		issue(build_command(OP_QUAD, 1, 0, -1, -2, 1, 2, 0, 0, 0, 0));
	endtask

	// Random paths: mostly a move followed by drawing commands, some noise
	task automatic run_random(int count);
		logic [3:0] op;
		logic [3:0] last_op;
		bit         np;
		int         i;
		last_op = OP_CLOSE;
		for (i = 0; i < count; i++) begin
			if (i >= count - QUIET_TAIL)
				quiet = 1'b1;
			np = 1'b0;
			if ($urandom_range(0, 15) == 0) begin
				op = OP_MOVE;
				np = 1'b1;
			end else if ((last_op == OP_CUBIC || last_op == OP_SCUBIC)
					&& $urandom_range(0, 1)) begin
				op = OP_SCUBIC;
			end else if ((last_op == OP_QUAD || last_op == OP_SQUAD)
					&& $urandom_range(0, 1)) begin
				op = OP_SQUAD;
			end else if ($urandom_range(0, 19) == 0) begin
				op = 4'($urandom_range(10, 15));
			end else begin
				op = 4'($urandom_range(0, 9));
			end
			if ($urandom_range(0, 29) == 0)
				np = 1'b1;
			issue(random_command(op, np));
			last_op = op;
		end
	endtask

	// Receiver: random stall bursts, one long hold-off, none in the tail
	initial begin
		wait (arst_n === 1'b1);
		forever begin
			if (long_hold) begin
				elem_stall <= 1'b1;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
				long_hold = 1'b0;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				elem_stall <= 1'b1;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end else begin
				elem_stall <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	// Output monitor
	always @(posedge clk) begin
		if (arst_n && elem_valid && !elem_stall)
			sb.check_element(elem);
	end

	// Watchdog on cycles without any accepted request or element
	always @(posedge clk) begin
		if (!arst_n || (cmd_valid && !cmd_stall) || (elem_valid && !elem_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Main sequence
	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		long_hold = 1'b1;
		run_random(RANDOM_ITEMS);
		cmd_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

`default_nettype wire
